// ===== hdl/brd_pkg.sv =====
// shared types, constants and helpers of the binary result row decoder
`timescale 1ns / 1ps
package brd_pkg;

   localparam int MAX_COLUMNS_DEF = 16;
   localparam int COL_W = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_KINDS = 2'd1;

   localparam logic [3:0] KIND_TINY     = 4'd0;
   localparam logic [3:0] KIND_SHORT    = 4'd1;
   localparam logic [3:0] KIND_INT32    = 4'd2;
   localparam logic [3:0] KIND_INT64    = 4'd3;
   localparam logic [3:0] KIND_FLOAT    = 4'd4;
   localparam logic [3:0] KIND_DOUBLE   = 4'd5;
   localparam logic [3:0] KIND_DATETIME = 4'd6;
   localparam logic [3:0] KIND_TIME     = 4'd7;
   localparam logic [3:0] KIND_DATE     = 4'd8;
   localparam logic [3:0] KIND_BYTES    = 4'd9;

   localparam logic [7:0] LEN_NULL  = 8'd251;
   localparam logic [7:0] LEN_EXT2  = 8'd252;
   localparam logic [7:0] LEN_EXT3  = 8'd253;

   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_BITMAP  = 6'b000010,
      PH_FIXED   = 6'b000100,
      PH_PREFIX  = 6'b001000,
      PH_EXT     = 6'b010000,
      PH_PAYLOAD = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      CS_IDLE = 2'b01,
      CS_SCAN = 2'b10
   } ctrl_state_type;

   typedef struct packed {
      logic step;
      logic scan_null;
      logic scan_open;
      logic scan_end;
   } cmd_type;

   typedef struct packed {
      logic step_emit;
      logic step_open;
      logic scan_end;
      logic scan_null;
   } status_type;

   function automatic logic [3:0] kind_of(input logic [63:0] kinds, input logic [3:0] col);
      logic [3:0] k;
      k = kinds[{col, 2'b00} +: 4];
      return (k > KIND_BYTES) ? KIND_BYTES : k;
   endfunction

   function automatic logic [3:0] fixed_len(input logic [3:0] k);
      logic [3:0] len;
      case (k)
         KIND_TINY:   len = 4'd1;
         KIND_SHORT:  len = 4'd2;
         KIND_INT32:  len = 4'd4;
         KIND_INT64:  len = 4'd8;
         KIND_FLOAT:  len = 4'd4;
         KIND_DOUBLE: len = 4'd8;
         default:     len = 4'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== hdl/brd_if.sv =====
// channel interfaces of the row decoder: byte input, result output, register writes
`timescale 1ns / 1ps
interface brd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_row;
   modport source (output valid, output data_byte, output start_of_row, input ready);
   modport sink (input valid, input data_byte, input start_of_row, output ready);
endinterface

interface brd_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         column;
   logic               is_null;
   logic [3:0]         kind;
   logic signed [63:0] value;
   logic               byte_valid;
   logic               column_done;
   logic               row_done;
   modport source (output valid, output column, output is_null, output kind, output value,
                   output byte_valid, output column_done, output row_done, input ready);
   modport sink (input valid, input column, input is_null, input kind, input value,
                 input byte_valid, input column_done, input row_done, output ready);
endinterface

interface brd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/brd_ctrl.sv =====
// controller: input acceptance, null column scan sequencing, result valid
`timescale 1ns / 1ps
module brd_ctrl
   import brd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type sts,
   output cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;
   logic           load;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == CS_IDLE) && out_free;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      load     = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.step = 1'b1;
               load     = sts.step_emit;
               if (sts.step_open) begin
                  state_in = CS_SCAN;
               end
            end
         end
         CS_SCAN: begin
            if (sts.scan_end) begin
               cmd.scan_end = 1'b1;
               state_in     = CS_IDLE;
            end else if (!sts.scan_null) begin
               cmd.scan_open = 1'b1;
               state_in      = CS_IDLE;
            end else if (out_free) begin
               // null column: one result per cycle while the output is free
               cmd.scan_null = 1'b1;
               load          = 1'b1;
            end
         end
         default: state_in = CS_IDLE;
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/brd_datapath.sv =====
// datapath: parse state, field assembly and result register
`timescale 1ns / 1ps
module brd_datapath
   import brd_pkg::*;
#(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  data_byte,
   input  logic        start_of_row,
   input  logic [4:0]  column_count,
   input  logic [63:0] column_kinds,
   input  cmd_type     cmd,
   output status_type  sts,
   output logic [3:0]  column,
   output logic        is_null,
   output logic [3:0]  kind,
   output logic [63:0] value,
   output logic        byte_valid,
   output logic        column_done,
   output logic        row_done
);

   localparam int BM_BYTES = (MAX_COLUMNS + 9) / 8;
   localparam int BM_W     = BM_BYTES * 8;

   phase_type         phase_ff, phase_in;
   logic [BM_W-1:0]   bm_ff, bm_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [3:0]        left_ff, left_in;
   logic [31:0]       len_ff, len_in;
   logic [31:0]       bs_ff, bs_in;
   logic [63:0]       asm_ff, asm_in;
   logic [31:0]       day_ff, day_in;

   logic [3:0]        column_ff;
   logic              is_null_ff;
   logic [3:0]        kind_ff;
   logic [63:0]       value_ff;
   logic              byte_valid_ff;
   logic              column_done_ff;
   logic              row_done_ff;

   logic [COL_W-1:0]  eff;
   logic [1:0]        bm_need;
   logic [BM_W-1:0]   bm_sh;

   logic              emit, open;
   logic [COL_W-1:0]  r_col;
   logic              r_null, r_bv, r_done;
   logic [63:0]       r_val;

   always_comb begin
      if (column_count == '0) begin
         eff = COL_W'(1);
      end else if (column_count > COL_W'(MAX_COLUMNS)) begin
         eff = COL_W'(MAX_COLUMNS);
      end else begin
         eff = column_count;
      end
      bm_need = 2'((eff + COL_W'(9)) >> 3);
      bm_sh   = bm_ff >> col_ff;
   end

   assign sts.scan_end  = (col_ff >= eff);
   assign sts.scan_null = bm_sh[2];
   assign sts.step_emit = emit;
   assign sts.step_open = open;

   always_comb begin
      phase_type   ph;
      logic [3:0]  k;
      logic [3:0]  flen;
      logic [63:0] v;
      logic        last;
      logic [31:0] bs_m1;
      logic [16:0] hsum;
      logic [15:0] hour;

      phase_in = phase_ff;
      bm_in    = bm_ff;
      col_in   = col_ff;
      left_in  = left_ff;
      len_in   = len_ff;
      bs_in    = bs_ff;
      asm_in   = asm_ff;
      day_in   = day_ff;
      emit     = 1'b0;
      open     = 1'b0;
      r_col    = col_ff;
      r_null   = 1'b0;
      r_val    = '0;
      r_bv     = 1'b0;
      r_done   = 1'b1;
      ph       = phase_ff;
      k        = kind_of(column_kinds, col_ff[3:0]);
      flen     = '0;
      v        = '0;
      last     = 1'b0;
      bs_m1    = '0;
      hsum     = '0;
      hour     = '0;

      if (cmd.step) begin
         if (start_of_row) begin
            ph      = PH_BITMAP;
            bm_in   = '0;
            col_in  = '0;
            left_in = '0;
            len_in  = '0;
            bs_in   = '0;
            asm_in  = '0;
            day_in  = '0;
         end
         r_col = col_in;
         k     = kind_of(column_kinds, col_in[3:0]);
         case (ph)
            PH_BITMAP: begin
               phase_in = PH_BITMAP;
               if (bs_in < 32'(BM_BYTES)) begin
                  bm_in = bm_in | (BM_W'(data_byte) << {bs_in[1:0], 3'b000});
               end
               bs_in = bs_in + 32'd1;
               if (bs_in >= 32'(bm_need)) begin
                  open   = 1'b1;
                  col_in = '0;
               end
            end
            PH_FIXED: begin
               flen = fixed_len(k);
               if (flen == '0) begin
                  flen = 4'd1;
               end
               if (bs_in < 32'd8) begin
                  asm_in = asm_in | (64'(data_byte) << {bs_in[2:0], 3'b000});
               end
               bs_in = bs_in + 32'd1;
               if (bs_in >= 32'(flen)) begin
                  v = asm_in;
                  if (k == KIND_SHORT) begin
                     v = {{48{asm_in[15]}}, asm_in[15:0]};
                  end else if (k == KIND_INT32) begin
                     v = {{32{asm_in[31]}}, asm_in[31:0]};
                  end
                  emit   = 1'b1;
                  r_val  = v;
                  open   = 1'b1;
                  col_in = col_in + COL_W'(1);
               end
            end
            PH_PREFIX: begin
               if (data_byte < LEN_NULL) begin
                  len_in = 32'(data_byte);
                  if (data_byte == '0) begin
                     emit   = 1'b1;
                     open   = 1'b1;
                     col_in = col_in + COL_W'(1);
                  end else begin
                     phase_in = PH_PAYLOAD;
                     bs_in    = '0;
                     asm_in   = '0;
                     day_in   = '0;
                  end
               end else if (data_byte == LEN_NULL) begin
                  emit   = 1'b1;
                  r_null = 1'b1;
                  open   = 1'b1;
                  col_in = col_in + COL_W'(1);
               end else begin
                  left_in  = (data_byte == LEN_EXT2) ? 4'd2 :
                             (data_byte == LEN_EXT3) ? 4'd3 : 4'd8;
                  bs_in    = '0;
                  len_in   = '0;
                  phase_in = PH_EXT;
               end
            end
            PH_EXT: begin
               if (bs_in < 32'd4) begin
                  len_in = len_in | (32'(data_byte) << {bs_in[1:0], 3'b000});
               end else if (data_byte != '0) begin
                  // upper half nonzero saturates the length
                  len_in = '1;
               end
               bs_in = bs_in + 32'd1;
               if (left_in != '0) begin
                  left_in = left_in - 4'd1;
               end
               if (left_in == '0) begin
                  if (len_in == '0) begin
                     emit   = 1'b1;
                     open   = 1'b1;
                     col_in = col_in + COL_W'(1);
                  end else begin
                     phase_in = PH_PAYLOAD;
                     bs_in    = '0;
                     asm_in   = '0;
                     day_in   = '0;
                  end
               end
            end
            PH_PAYLOAD: begin
               last  = ({1'b0, bs_in} + 33'd1) >= {1'b0, len_in};
               bs_m1 = bs_in - 32'd1;
               if (k == KIND_DATETIME || k == KIND_DATE) begin
                  if (bs_in == 32'd0) begin
                     asm_in[55:48] = asm_in[55:48] | data_byte;
                  end else if (bs_in == 32'd1) begin
                     asm_in[63:56] = asm_in[63:56] | data_byte;
                  end else if (bs_in == 32'd2) begin
                     asm_in[47:40] = asm_in[47:40] | data_byte;
                  end else if (bs_in == 32'd3) begin
                     asm_in[39:32] = asm_in[39:32] | data_byte;
                  end else if (k == KIND_DATETIME && bs_in == 32'd4) begin
                     asm_in[23:16] = asm_in[23:16] | data_byte;
                  end else if (k == KIND_DATETIME && bs_in == 32'd5) begin
                     asm_in[15:8] = asm_in[15:8] | data_byte;
                  end else if (k == KIND_DATETIME && bs_in == 32'd6) begin
                     asm_in[7:0] = asm_in[7:0] | data_byte;
                  end
               end else if (k == KIND_TIME) begin
                  // sign byte dropped, then four day bytes
                  if (bs_in >= 32'd1 && bs_in <= 32'd4) begin
                     day_in = day_in | (32'(data_byte) << {bs_m1[1:0], 3'b000});
                  end else if (bs_in == 32'd5) begin
                     asm_in[23:16] = asm_in[23:16] | data_byte;
                  end else if (bs_in == 32'd6) begin
                     asm_in[15:8] = asm_in[15:8] | data_byte;
                  end else if (bs_in == 32'd7) begin
                     asm_in[7:0] = asm_in[7:0] | data_byte;
                  end
               end
               bs_in = bs_in + 32'd1;
               if (k == KIND_DATETIME || k == KIND_DATE || k == KIND_TIME) begin
                  if (last) begin
                     if (k == KIND_TIME) begin
                        // days fold into hours, saturating
                        hsum = 17'(day_in[11:0]) * 17'd24 + 17'(asm_in[23:16]);
                        if (day_in > 32'd2730 || hsum > 17'd65535) begin
                           hour = 16'hFFFF;
                        end else begin
                           hour = hsum[15:0];
                        end
                        asm_in = {32'd0, hour, asm_in[15:0]};
                     end
                     emit   = 1'b1;
                     r_val  = asm_in;
                     open   = 1'b1;
                     col_in = col_in + COL_W'(1);
                  end
               end else begin
                  emit   = 1'b1;
                  r_val  = 64'(data_byte);
                  r_bv   = 1'b1;
                  r_done = last;
                  if (last) begin
                     open   = 1'b1;
                     col_in = col_in + COL_W'(1);
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end else if (cmd.scan_null) begin
         emit   = 1'b1;
         r_null = 1'b1;
         col_in = col_ff + COL_W'(1);
      end else if (cmd.scan_open) begin
         phase_in = (fixed_len(k) != '0) ? PH_FIXED : PH_PREFIX;
         bs_in    = '0;
         asm_in   = '0;
         day_in   = '0;
         len_in   = '0;
         left_in  = '0;
      end else if (cmd.scan_end) begin
         phase_in = PH_IDLE;
         col_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bm_ff    <= '0;
         col_ff   <= '0;
         left_ff  <= '0;
         len_ff   <= '0;
         bs_ff    <= '0;
         asm_ff   <= '0;
         day_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         bm_ff    <= bm_in;
         col_ff   <= col_in;
         left_ff  <= left_in;
         len_ff   <= len_in;
         bs_ff    <= bs_in;
         asm_ff   <= asm_in;
         day_ff   <= day_in;
      end
   end

   // result register; a column at or past the last one ends the row
   always_ff @(posedge clock) begin
      if ((cmd.step && emit) || cmd.scan_null) begin
         column_ff      <= r_col[3:0];
         is_null_ff     <= r_null;
         kind_ff        <= kind_of(column_kinds, r_col[3:0]);
         value_ff       <= r_val;
         byte_valid_ff  <= r_bv;
         column_done_ff <= r_done;
         row_done_ff    <= r_done && (r_col >= eff - COL_W'(1));
      end
   end

   assign column      = column_ff;
   assign is_null     = is_null_ff;
   assign kind        = kind_ff;
   assign value       = value_ff;
   assign byte_valid  = byte_valid_ff;
   assign column_done = column_done_ff;
   assign row_done    = row_done_ff;

endmodule

// ===== hdl/binary_result_row_decoder.sv =====
// Binary result row decoder: one row byte per transfer, column results out.
// Latency: a result is offered in the cycle after the transfer that completes it.
// Throughput: one byte per cycle while the result side keeps up; a byte that
//   closes the bitmap or a column starts a column scan that holds off input;
//   the scan gives one null result per cycle while the result side keeps up.
// Reset: synchronous, clears parse state; column_count reads 1, column_kinds 0.
`timescale 1ns / 1ps
module binary_result_row_decoder
   import brd_pkg::*;
#(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
   input logic       clock,
   input logic       reset,
   brd_req_if.sink   req_bus,
   brd_rsp_if.source rsp_bus,
   brd_csr_if.sink   csr_bus
);

   logic [4:0]  column_count_ff;
   logic [63:0] column_kinds_ff;
   cmd_type     cmd;
   status_type  sts;
   logic [63:0] value;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= 5'd1;
         column_kinds_ff <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_COLUMN_COUNT: column_count_ff <= csr_bus.data[4:0];
            CSR_COLUMN_KINDS: column_kinds_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   brd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   brd_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .data_byte    (req_bus.data_byte),
      .start_of_row (req_bus.start_of_row),
      .column_count (column_count_ff),
      .column_kinds (column_kinds_ff),
      .cmd          (cmd),
      .sts          (sts),
      .column       (rsp_bus.column),
      .is_null      (rsp_bus.is_null),
      .kind         (rsp_bus.kind),
      .value        (value),
      .byte_valid   (rsp_bus.byte_valid),
      .column_done  (rsp_bus.column_done),
      .row_done     (rsp_bus.row_done)
   );

   assign rsp_bus.value = signed'(value);

endmodule

// ===== hdl/brd_checker.sv =====
// port checker of the row decoder, bound to the top level
`timescale 1ns / 1ps
module brd_checker
   import brd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  column,
   input logic        is_null,
   input logic [3:0]  kind,
   input logic [63:0] value,
   input logic        byte_valid,
   input logic        column_done,
   input logic        row_done
);

   // stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(value) && $stable(column))
      else $error("result changed while stalled");

   a_row_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && row_done |-> column_done)
      else $error("row done without column done");

   a_null: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_null |-> value == 64'd0 && !byte_valid && column_done)
      else $error("null result malformed");

   // date and time payloads never stream partial results
   a_partial: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !column_done |-> byte_valid && !row_done && kind != KIND_DATETIME
         && kind != KIND_TIME && kind != KIND_DATE)
      else $error("partial column result not a payload byte");

endmodule

bind binary_result_row_decoder brd_checker u_brd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .column      (rsp_bus.column),
   .is_null     (rsp_bus.is_null),
   .kind        (rsp_bus.kind),
   .value       (rsp_bus.value),
   .byte_valid  (rsp_bus.byte_valid),
   .column_done (rsp_bus.column_done),
   .row_done    (rsp_bus.row_done)
);

// ===== dv/binary_result_row_decoder_tb.sv =====
// testbench of the binary result row decoder: directed and random row streams checked by a scoreboard
`timescale 1ns / 1ps
module binary_result_row_decoder_tb;
   import brd_pkg::*;

   typedef struct {
      logic [3:0]  column;
      logic        is_null;
      logic [3:0]  kind;
      logic [63:0] value;
      logic        byte_valid;
      logic        column_done;
      logic        row_done;
   } column_result_t;

   localparam logic [2:0] ST_IDLE = 3'd0, ST_BITMAP = 3'd1, ST_FIXED = 3'd2,
                          ST_PREFIX = 3'd3, ST_EXT = 3'd4, ST_PAYLOAD = 3'd5;

   class row_scoreboard;
      logic [4:0]  column_count;
      logic [63:0] column_kinds;
      logic [2:0]  phase;
      logic [31:0] nulls;
      logic [3:0]  col;
      logic [3:0]  ext_left;
      logic [31:0] field_len;
      logic [31:0] seen;
      logic [63:0] acc;
      logic [31:0] days;
      column_result_t pending[$];
      int errors;
      int results_checked;

      function new();
         column_count = 1; column_kinds = 0; phase = ST_IDLE; nulls = 0; col = 0;
         ext_left = 0; field_len = 0; seen = 0; acc = 0; days = 0; errors = 0;
         results_checked = 0;
      endfunction

      function int ncols();
         int c;
         c = int'(column_count);
         if (c < 1) c = 1;
         if (c > 16) c = 16;
         return c;
      endfunction

      function logic [3:0] kind_at(int c);
         logic [3:0] k;
         k = column_kinds[4*c +: 4];
         return (k > KIND_BYTES) ? KIND_BYTES : k;
      endfunction

      function int width_of(logic [3:0] k);
         case (k)
            KIND_TINY: return 1;
            KIND_SHORT: return 2;
            KIND_INT32, KIND_FLOAT: return 4;
            KIND_INT64, KIND_DOUBLE: return 8;
            default: return 0;
         endcase
      endfunction

      function void push(logic nul, logic [63:0] v, logic bv, logic done);
         column_result_t r;
         r.column = col; r.is_null = nul; r.kind = kind_at(col); r.value = v;
         r.byte_valid = bv; r.column_done = done; r.row_done = 0;
         pending = {pending, r};
      endfunction

      function void open_from(int c, int first);
         forever begin
            if (c >= ncols()) begin
               if (pending.size() > first) pending[pending.size()-1].row_done = 1;
               phase = ST_IDLE; col = 0;
               return;
            end
            col = c;
            if (nulls[c+2]) begin
               push(1, 0, 0, 1);
               c++;
            end else begin
               seen = 0; acc = 0; days = 0; field_len = 0; ext_left = 0;
               phase = (width_of(kind_at(c)) != 0) ? ST_FIXED : ST_PREFIX;
               return;
            end
         end
      endfunction

      function void finish(logic [63:0] v, int first);
         push(0, v, 0, 1);
         open_from(col + 1, first);
      endfunction

      function void got_length(int first);
         if (field_len == 0) finish(0, first);
         else begin
            phase = ST_PAYLOAD; seen = 0; acc = 0; days = 0;
         end
      endfunction

      function void note_byte(logic [7:0] b, logic sor);
         int first, len;
         logic [3:0] k;
         logic [63:0] v, h;
         logic last;
         first = pending.size();
         if (sor) begin
            phase = ST_BITMAP; nulls = 0; col = 0; ext_left = 0; field_len = 0;
            seen = 0; acc = 0; days = 0;
         end
         case (phase)
            ST_BITMAP: begin
               if (seen < 3) nulls |= 32'(b) << (8*seen);
               seen++;
               if (seen >= (ncols() + 9) / 8) open_from(0, first);
            end
            ST_FIXED: begin
               k = kind_at(col);
               len = width_of(k);
               if (len == 0) len = 1;
               if (seen < 8) acc |= 64'(b) << (8*seen);
               seen++;
               if (seen >= len) begin
                  v = acc;
                  if (k == KIND_SHORT) v = {{48{v[15]}}, v[15:0]};
                  else if (k == KIND_INT32) v = {{32{v[31]}}, v[31:0]};
                  finish(v, first);
               end
            end
            ST_PREFIX: begin
               if (b < LEN_NULL) begin
                  field_len = 32'(b); got_length(first);
               end else if (b == LEN_NULL) begin
                  push(1, 0, 0, 1); open_from(col + 1, first);
               end else begin
                  ext_left = (b == LEN_EXT2) ? 4'd2 : (b == LEN_EXT3) ? 4'd3 : 4'd8;
                  seen = 0; field_len = 0; phase = ST_EXT;
               end
            end
            ST_EXT: begin
               if (seen < 4) field_len |= 32'(b) << (8*seen);
               else if (b != 0) field_len = 32'hFFFF_FFFF;
               seen++;
               if (ext_left > 0) ext_left--;
               if (ext_left == 0) got_length(first);
            end
            ST_PAYLOAD: begin
               k = kind_at(col);
               last = (64'(seen) + 1) >= 64'(field_len);
               if (k == KIND_DATETIME || k == KIND_DATE) begin
                  case (seen)
                     0: acc |= 64'(b) << 48;
                     1: acc |= 64'(b) << 56;
                     2: acc |= 64'(b) << 40;
                     3: acc |= 64'(b) << 32;
                     4: if (k == KIND_DATETIME) acc |= 64'(b) << 16;
                     5: if (k == KIND_DATETIME) acc |= 64'(b) << 8;
                     6: if (k == KIND_DATETIME) acc |= 64'(b);
                     default: ;
                  endcase
               end else if (k == KIND_TIME) begin
                  if (seen >= 1 && seen <= 4) days |= 32'(b) << (8*(seen-1));
                  else if (seen == 5) acc |= 64'(b) << 16;
                  else if (seen == 6) acc |= 64'(b) << 8;
                  else if (seen == 7) acc |= 64'(b);
               end
               seen++;
               if (k != KIND_DATETIME && k != KIND_DATE && k != KIND_TIME) begin
                  push(0, 64'(b), 1, last);
                  if (last) open_from(col + 1, first);
               end else if (last) begin
                  if (k == KIND_TIME) begin
                     h = 64'(acc[23:16]) + 64'(days) * 64'd24;
                     if (h > 64'd65535) h = 64'd65535;
                     acc = {32'd0, h[15:0], acc[15:0]};
                  end
                  finish(acc, first);
               end
            end
            default: phase = ST_IDLE;
         endcase
      endfunction

      function void check(column_result_t a);
         column_result_t e;
         results_checked++;
         if (pending.size() == 0) begin
            $error("unexpected result column=%0d value=%h", a.column, a.value);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.column !== e.column) begin
            $error("column exp %0d got %0d", e.column, a.column); errors++; end
         if (a.is_null !== e.is_null) begin
            $error("is_null exp %0d got %0d", e.is_null, a.is_null); errors++; end
         if (a.kind !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, a.kind); errors++; end
         if (a.value !== e.value) begin
            $error("value exp %h got %h", e.value, a.value); errors++; end
         if (a.byte_valid !== e.byte_valid) begin
            $error("byte_valid exp %0d got %0d", e.byte_valid, a.byte_valid); errors++; end
         if (a.column_done !== e.column_done) begin
            $error("column_done exp %0d got %0d", e.column_done, a.column_done); errors++; end
         if (a.row_done !== e.row_done) begin
            $error("row_done exp %0d got %0d", e.row_done, a.row_done); errors++; end
      endfunction
   endclass

   logic clock, reset;
   brd_req_if req_bus();
   brd_rsp_if rsp_bus();
   brd_csr_if csr_bus();
   row_scoreboard sb;
   int bytes_sent;
   int burst_left;
   logic stall_on;

   binary_result_row_decoder dut (.clock(clock), .reset(reset), .req_bus(req_bus),
                                  .rsp_bus(rsp_bus), .csr_bus(csr_bus));

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver stall pattern: alternate long runs ready and stalled runs
   initial begin
      rsp_bus.ready = 0;
      stall_on = 0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 15) == 0) stall_on = ~stall_on;
         rsp_bus.ready = stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   always @(posedge clock) begin
      column_result_t r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         r.column = rsp_bus.column; r.is_null = rsp_bus.is_null; r.kind = rsp_bus.kind;
         r.value = rsp_bus.value; r.byte_valid = rsp_bus.byte_valid;
         r.column_done = rsp_bus.column_done; r.row_done = rsp_bus.row_done;
         sb.check(r);
      end
   end

   task automatic send_byte(logic [7:0] b, logic sor);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_bus.valid <= 0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_bus.valid <= 1;
      req_bus.data_byte <= b;
      req_bus.start_of_row <= sor;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_byte(b, sor);
      bytes_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [63:0] val);
      drain();
      csr_bus.valid <= 1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == CSR_COLUMN_COUNT) sb.column_count = val[4:0];
      else if (idx == CSR_COLUMN_KINDS) sb.column_kinds = val;
      @(negedge clock);
      csr_bus.valid <= 0;
   endtask

   // one well-formed row with random content; broken rows cut it short
   task automatic send_row(logic cut);
      int n, nb, c, len, stop, i;
      logic [23:0] bm;
      logic [3:0] k;
      n = sb.ncols();
      nb = (n + 9) / 8;
      bm = 24'($urandom) & ((($urandom_range(0, 1)) ? 24'hFFFFFF : 24'h924924));
      if ($urandom_range(0, 3) == 0) bm = 0;
      stop = cut ? $urandom_range(1, 20) : 1 << 30;
      for (i = 0; i < nb; i++) send_byte(bm[8*i +: 8], i == 0);
      for (c = 0; c < n && stop > 0; c++) begin
         if (bm[c+2]) continue;
         k = sb.kind_at(c);
         len = sb.width_of(k);
         if (len != 0) begin
            for (i = 0; i < len; i++) send_byte(8'($urandom), 0);
         end else begin
            case ($urandom_range(0, 7))
               0: begin send_byte(LEN_NULL, 0); len = -1; end
               1: begin len = $urandom_range(0, 12); send_byte(LEN_EXT2, 0);
                  send_byte(8'(len), 0); send_byte(0, 0); end
               2: begin len = $urandom_range(0, 5); send_byte(LEN_EXT3, 0);
                  send_byte(8'(len), 0); send_byte(0, 0); send_byte(0, 0); end
               3: begin len = $urandom_range(0, 4); send_byte(8'd254, 0);
                  send_byte(8'(len), 0); repeat (7) send_byte(0, 0); end
               default: begin
                  len = (k == KIND_BYTES) ? $urandom_range(0, 6)
                        : (($urandom_range(0, 1)) ? $urandom_range(0, 12) : 8);
                  send_byte(8'(len), 0);
               end
            endcase
            for (i = 0; i < len; i++) send_byte(8'($urandom), 0);
         end
         stop--;
      end
   endtask

   function automatic logic [63:0] rand_kinds();
      logic [63:0] v;
      v = {$urandom, $urandom};
      for (int i = 0; i < 16; i++) if (v[4*i +: 4] > 9 && $urandom_range(0, 2) != 0)
         v[4*i +: 4] = 4'($urandom_range(0, 9));
      return v;
   endfunction

   initial begin
      sb = new();
      bytes_sent = 0;
      burst_left = 0;
      req_bus.valid = 0; req_bus.data_byte = 0; req_bus.start_of_row = 0;
      csr_bus.valid = 0; csr_bus.index = 0; csr_bus.data = 0;
      reset = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: stray bytes, extremes, null and long length codes
      send_byte(8'hFF, 0);
      send_byte(8'h00, 1); send_byte(8'hFF, 0);
      send_byte(8'h00, 1); send_byte(8'h80, 0); send_byte(8'h7F, 0);
      write_reg(CSR_COLUMN_COUNT, 5);
      write_reg(CSR_COLUMN_KINDS, 64'h9_8_7_6_5);
      send_byte(8'h00, 1); send_byte(8'h00, 0);
      send_byte(8'd251, 0);
      send_byte(8'd254, 0); send_byte(1, 0); repeat (6) send_byte(0, 0); send_byte(1, 0);
      send_byte(8'd0, 1); send_byte(8'd0, 0);
      send_row(0);
      write_reg(CSR_COLUMN_COUNT, 16);
      write_reg(CSR_COLUMN_KINDS, 64'hFFFF_FFFF_FFFF_FFFF);
      send_byte(8'hFC, 1); send_byte(8'hFF, 0); send_byte(8'h03, 0);
      write_reg(CSR_COLUMN_COUNT, 0);
      send_row(0);
      write_reg(CSR_COLUMN_COUNT, 31);
      write_reg(CSR_COLUMN_KINDS, 64'h0);
      send_row(0);
      drain();

      while (bytes_sent < 100) begin
         if ($urandom_range(0, 3) == 0) begin
            write_reg(CSR_COLUMN_COUNT, 64'($urandom_range(0, 31)));
            write_reg(CSR_COLUMN_KINDS, rand_kinds());
         end
         case ($urandom_range(0, 9))
            0: send_byte(8'($urandom), 0);
            1: send_row(1);
            default: send_row(0);
         endcase
      end
      drain();
      $display("sent %0d row bytes, checked %0d column results across random layouts",
               bytes_sent, sb.results_checked);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
